// ===== hw/rtl/bscf_pkg.sv =====
// shared types and constants for the bit vector set/clear/find-first block
package bscf_pkg;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OP_TEST      = 2'd0,
      OP_SET       = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_CLEAR_ALL = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_TZC,
      ST_DONE
   } state_type;

   // trailing zero unit control and status
   typedef struct packed {
      logic        start;
      logic [63:0] word;
   } tzc_ctrl_type;

   typedef struct packed {
      logic       done;
      logic [5:0] pos;
   } tzc_stat_type;

   localparam int WORD_BITS = 64;
   localparam int TZ_STEPS  = 6;

   // halving masks and shift amounts of the lowest-set search
   localparam logic [63:0] TZ_MASK [TZ_STEPS] = '{
      64'h0000_0000_FFFF_FFFF, 64'h0000_FFFF, 64'h00FF, 64'h0F, 64'h3, 64'h1
   };
   localparam logic [5:0] TZ_SHIFT [TZ_STEPS] = '{
      6'd32, 6'd16, 6'd8, 6'd4, 6'd2, 6'd1
   };

   localparam logic [11:0] COUNT_MAX   = 12'd4095;
   localparam logic [11:0] LOWEST_MAX  = 12'd2047;
   localparam logic [11:0] LOWEST_NONE = 12'hFFF;

endpackage

// ===== hw/rtl/bscf_mem.sv =====
// word store: one write port, one registered read port
module bscf_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bscf_tzc.sv =====
// iterative trailing zero count of a nonzero word, one halving step a cycle
module bscf_tzc
   import bscf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tzc_ctrl_type ctrl,
   output tzc_stat_type stat
);

   logic [63:0] word_ff, word_in;
   logic [5:0]  pos_ff, pos_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        low_zero;

   assign low_zero = (word_ff & TZ_MASK[step_ff]) == 64'd0;

   always_comb begin
      word_in = word_ff;
      pos_in  = pos_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         word_in = ctrl.word;
         pos_in  = 6'd0;
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (low_zero) begin
            word_in = word_ff >> TZ_SHIFT[step_ff];
            pos_in  = pos_ff | TZ_SHIFT[step_ff];
         end
         if (step_ff == 3'(TZ_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      pos_ff  <= pos_in;
   end

   assign stat.done = done_ff;
   assign stat.pos  = pos_ff;

endmodule

// ===== hw/rtl/bitmap_set_clear_find_first_top.sv =====
// bit vector store with test/set/clear/clear-all, running set count and lowest-set search
// test, set, clear pass from accept through read-modify-write (ST_READ) to respond (ST_DONE)
// a new item is taken only once the last is back in idle; a clear that removes the lowest of
//   several set bits adds a trailing zero search, after an upward word scan if its word empties
// clear whole vector sweeps one word a cycle, then responds; reset runs the same sweep
//   with no result, no item taken
module bitmap_set_clear_find_first_top
   import bscf_pkg::*;
#(
   parameter int NBITS  = 2048,
   parameter int NWORDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [10:0] req_bit_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_was_set,
   output logic [11:0] rsp_set_count,
   output logic [11:0] rsp_lowest_set
);

   // word address width, width of a stored bit position, set count width and last word address
   localparam int AW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int LW    = AW + 6;
   localparam int CNT_W = $clog2(NBITS + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NWORDS - 1);

   // sequencer and item registers
   state_type      state_ff, state_in;
   op_type         op_ff, op_in;
   logic [10:0]    idx_ff, idx_in;
   logic           in_range_ff, in_range_in;
   logic           was_ff, was_in;
   logic           clr_resp_ff, clr_resp_in;
   logic [AW-1:0]  sweep_addr_ff, sweep_addr_in;
   logic [AW-1:0]  scan_addr_ff, scan_addr_in;

   // vector summary: set count, empty flag and lowest set position
   logic [CNT_W-1:0] count_ff, count_in;
   logic             empty_ff, empty_in;
   logic [LW-1:0]    low_ff, low_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_was_ff, rsp_was_in;
   logic [11:0] rsp_count_ff, rsp_count_in;
   logic [11:0] rsp_low_ff, rsp_low_in;

   // memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_data;

   tzc_ctrl_type tzc_ctrl;
   tzc_stat_type tzc_stat;

   // decode of the item held and the word just read
   logic          accept;
   logic [31:0]   req_word_ext;
   logic          req_in_range;
   logic [AW-1:0] addr_ff;
   logic [63:0]   bit_sel;
   logic          was_now;
   logic          do_set;
   logic          do_clr;
   logic [63:0]   new_word;
   logic [LW-1:0] idx_low;
   logic          hit_low;
   logic          need_tzc;
   logic          need_scan;
   logic          sweep_last;
   logic          scan_nz;
   logic          scan_last;
   logic [31:0]   count_ext;
   logic [31:0]   low_ext;

   assign accept       = req_valid && req_ready;
   assign req_word_ext = 32'(req_bit_index[10:6]);
   assign req_in_range = (32'(req_bit_index) < NBITS) && (req_word_ext < NWORDS);

   assign addr_ff  = AW'(32'(idx_ff[10:6]));
   assign bit_sel  = 64'd1 << idx_ff[5:0];
   assign idx_low  = LW'(32'(idx_ff));
   assign was_now  = in_range_ff && ((rd_data & bit_sel) != 64'd0);
   assign do_set   = in_range_ff && (op_ff == OP_SET) && !was_now;
   assign do_clr   = in_range_ff && (op_ff == OP_CLEAR) && was_now;
   assign new_word = do_set ? (rd_data | bit_sel) : (rd_data & ~bit_sel);

   // clearing the lowest bit while others remain forces a new search
   assign hit_low   = do_clr && (count_ff != CNT_W'(1)) && (idx_low == low_ff);
   assign need_tzc  = hit_low && (new_word != 64'd0);
   assign need_scan = hit_low && (new_word == 64'd0) && (addr_ff != LAST_ADDR);

   assign sweep_last = sweep_addr_ff == LAST_ADDR;
   assign scan_nz    = rd_data != 64'd0;
   assign scan_last  = scan_addr_ff == LAST_ADDR;

   assign count_ext = 32'(count_ff);
   assign low_ext   = 32'(low_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_last) begin
               state_in = clr_resp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_opcode) == OP_CLEAR_ALL) ? ST_CLEAR : ST_READ;
            end
         end
         ST_READ: begin
            priority if (need_tzc) begin
               state_in = ST_TZC;
            end else if (need_scan) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            priority if (scan_nz) begin
               state_in = ST_TZC;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_TZC: begin
            if (tzc_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and register updates
   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      in_range_in   = in_range_ff;
      was_in        = was_ff;
      clr_resp_in   = clr_resp_ff;
      sweep_addr_in = sweep_addr_ff;
      scan_addr_in  = scan_addr_ff;
      count_in      = count_ff;
      empty_in      = empty_ff;
      low_in        = low_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_was_in    = rsp_was_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_low_in    = rsp_low_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = new_word;
      rd_addr       = AW'(0);
      tzc_ctrl      = '{start: 1'b0, word: rd_data};

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one word a cycle
            wr_en   = 1'b1;
            wr_addr = sweep_addr_ff;
            wr_data = 64'd0;
            if (sweep_last) begin
               sweep_addr_in = AW'(0);
               count_in      = '0;
               empty_in      = 1'b1;
            end else begin
               sweep_addr_in = sweep_addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            rd_addr = AW'(req_word_ext);
            if (accept) begin
               op_in       = op_type'(req_opcode);
               idx_in      = req_bit_index;
               in_range_in = req_in_range;
               was_in      = 1'b0;
               clr_resp_in = op_type'(req_opcode) == OP_CLEAR_ALL;
            end
         end
         ST_READ: begin
            // read-modify-write of the addressed word
            was_in  = was_now;
            wr_en   = do_set || do_clr;
            rd_addr = addr_ff + AW'(1);
            if (do_set) begin
               count_in = count_ff + CNT_W'(1);
               if (empty_ff || (idx_low < low_ff)) begin
                  low_in   = idx_low;
                  empty_in = 1'b0;
               end
            end else if (do_clr) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  empty_in = 1'b1;
               end else if (hit_low && !need_tzc && !need_scan) begin
                  empty_in = 1'b1;
               end
            end
            if (need_tzc) begin
               tzc_ctrl     = '{start: 1'b1, word: new_word};
               scan_addr_in = addr_ff;
            end else if (need_scan) begin
               scan_addr_in = addr_ff + AW'(1);
            end
         end
         ST_SCAN: begin
            // walk upward until a nonzero word turns up or the last word reads zero
            rd_addr = scan_addr_ff + AW'(1);
            priority if (scan_nz) begin
               tzc_ctrl = '{start: 1'b1, word: rd_data};
            end else if (scan_last) begin
               empty_in = 1'b1;
            end else begin
               scan_addr_in = scan_addr_ff + AW'(1);
            end
         end
         ST_TZC: begin
            if (tzc_stat.done) begin
               low_in   = {scan_addr_ff, tzc_stat.pos};
               empty_in = 1'b0;
            end
         end
         ST_DONE: begin
            // load the result; count saturates at COUNT_MAX, lowest position at LOWEST_MAX
            rsp_valid_in = 1'b1;
            rsp_was_in   = was_ff;
            rsp_count_in = (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX : count_ext[11:0];
            if (empty_ff) begin
               rsp_low_in = LOWEST_NONE;
            end else begin
               rsp_low_in = (low_ext > 32'(LOWEST_MAX)) ? LOWEST_MAX : low_ext[11:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_resp_ff   <= 1'b0;
         sweep_addr_ff <= AW'(0);
         count_ff      <= '0;
         empty_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_resp_ff   <= clr_resp_in;
         sweep_addr_ff <= sweep_addr_in;
         count_ff      <= count_in;
         empty_ff      <= empty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      was_ff       <= was_in;
      scan_addr_ff <= scan_addr_in;
      low_ff       <= low_in;
      rsp_was_ff   <= rsp_was_in;
      rsp_count_ff <= rsp_count_in;
      rsp_low_ff   <= rsp_low_in;
   end

   // word memory
   bscf_mem #(
      .DEPTH (NWORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared lowest-set search unit
   bscf_tzc u_tzc (
      .clock (clock),
      .reset (reset),
      .ctrl  (tzc_ctrl),
      .stat  (tzc_stat)
   );

   // take an item only when idle and the result slot is free or draining
   assign req_ready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_set    = rsp_was_ff;
   assign rsp_set_count  = rsp_count_ff;
   assign rsp_lowest_set = rsp_low_ff;

endmodule
